// ===== rtl/tcfr_pkg.sv =====
// tcfr_pkg: shared types, codes and helpers of the telemetry command frame receiver
// used by tcfr_front, tcfr_queue, tcfr_back and the top level; no dependencies
`default_nettype none
package tcfr_pkg;

	localparam int GAINS_PER_GROUP_DEF = 9;
	localparam int PAY_IDX_W = 5;   // covers a payload of up to 2 * 9 bytes
	localparam int QDEPTH = 4;

	localparam logic [7:0] HDR0 = 8'hAA;
	localparam logic [7:0] HDR1 = 8'hAF;
	localparam logic [7:0] ACK_ID = 8'hEF;
	localparam logic [7:0] ACK_LEN = 8'h02;
	localparam logic [7:0] FC_CAL = 8'h01;
	localparam logic [7:0] FC_REQ = 8'h02;
	localparam logic [7:0] FC_GAIN_LO = 8'h10;
	localparam logic [7:0] FC_GAIN_SHORT = 8'h13;
	localparam logic [7:0] FC_ACK_HI = 8'h15;
	localparam logic [7:0] CMD_ACC = 8'h01;
	localparam logic [7:0] CMD_GYRO = 8'h02;
	localparam logic [7:0] CMD_BOTH = 8'h03;
	localparam logic [7:0] CMD_MAG = 8'h04;
	localparam logic [7:0] CMD_READBACK = 8'h01;
	localparam logic [7:0] CMD_VERSION = 8'hA0;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_GAIN = 2'd1;
	localparam logic [1:0] KIND_ACK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_HEADER = 2'd2;
	localparam logic [1:0] ST_SHORT = 2'd3;

	localparam logic [2:0] ACK_LAST = 3'd6;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} rx_item_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [1:0]         frame_status;
		logic               calibrate_accel;
		logic               calibrate_gyro;
		logic               calibrate_mag;
		logic               want_gain_readback;
		logic               want_version;
		logic               save_params;
		logic [5:0]         gain_slot;
		logic signed [15:0] gain_value;
		logic [7:0]         ack_byte;
		logic               last_result;
	} res_item_t;

	typedef struct packed {
		logic cal_accel;
		logic cal_gyro;
		logic cal_mag;
		logic readback;
		logic version;
		logic save;
	} frame_flags_t;

	// queue entry: either a payload byte write or a finished frame
	typedef struct packed {
		logic                 job;
		logic [1:0]           status;
		frame_flags_t         flags;
		logic [7:0]           fc;
		logic [7:0]           data;
		logic [PAY_IDX_W-1:0] addr;
	} q_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_GRD,
		BK_GOUT,
		BK_ACK
	} back_state_t;

	function automatic logic is_gain_fc(input logic [7:0] fc);
		return (fc >= FC_GAIN_LO) && (fc <= FC_GAIN_SHORT);
	endfunction

	function automatic logic is_ack_fc(input logic [7:0] fc);
		return (fc >= FC_GAIN_LO) && (fc <= FC_ACK_HI);
	endfunction

	// acknowledge frame: AA AA EF 02 fc sum checksum
	function automatic logic [7:0] ack_byte_f(input logic [2:0] k, input logic [7:0] fc,
			input logic [7:0] sum);
		logic [7:0] r;
		unique case (k)
			3'd0, 3'd1: r = HDR0;
			3'd2:       r = ACK_ID;
			3'd3:       r = ACK_LEN;
			3'd4:       r = fc;
			3'd5:       r = sum;
			default:    r = HDR0 + HDR0 + ACK_ID + ACK_LEN + fc + sum;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tcfr_front.sv =====
// tcfr_front: takes frame bytes, keeps position, sum and header check, classifies frame end
// pushes payload writes and frame jobs into tcfr_queue; depends on tcfr_pkg
`default_nettype none
module tcfr_front #(
	parameter int GAINS_PER_GROUP = tcfr_pkg::GAINS_PER_GROUP_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     rx_valid,
	output logic                    rx_stall,
	input  tcfr_pkg::rx_item_t      rx_data,
	input  wire                     q_full,
	output logic                    q_push,
	output tcfr_pkg::q_entry_t      q_wdata
);
	import tcfr_pkg::*;

	localparam int G13 = (GAINS_PER_GROUP < 3) ? GAINS_PER_GROUP : 3;
	localparam logic [7:0] LEN_GAIN = 8'(4 + 2 * GAINS_PER_GROUP);
	localparam logic [7:0] LEN_G13 = 8'(4 + 2 * G13);
	localparam logic [7:0] PAY_END = 8'(4 + 2 * GAINS_PER_GROUP);

	logic [7:0] pos_q, sum_q, fc_q, cmd_q;
	logic       hdr_q;
	logic       accept, in_store, gain_fc;
	logic [7:0] idx;
	logic [1:0] status;
	frame_flags_t flags;

	assign rx_stall = q_full;
	assign accept = rx_valid && !rx_stall;
	assign in_store = (pos_q >= 8'd4) && (pos_q < PAY_END);
	assign idx = pos_q - 8'd4;
	assign gain_fc = is_gain_fc(fc_q);

	always_comb begin
		priority if (sum_q != rx_data.rx_byte)
			status = ST_CHECKSUM;
		else if (pos_q < 8'd2)
			status = ST_SHORT;
		else if (!hdr_q)
			status = ST_HEADER;
		else if (pos_q < 8'd3)
			status = ST_SHORT;
		else if ((fc_q == FC_CAL || fc_q == FC_REQ) && pos_q < 8'd5)
			status = ST_SHORT;
		else if (gain_fc && pos_q < ((fc_q == FC_GAIN_SHORT) ? LEN_G13 : LEN_GAIN))
			status = ST_SHORT;
		else
			status = ST_OK;
	end

	always_comb begin
		flags = '0;
		if (status == ST_OK) begin
			if (fc_q == FC_CAL) begin
				flags.cal_accel = (cmd_q == CMD_ACC) || (cmd_q == CMD_BOTH);
				flags.cal_gyro = (cmd_q == CMD_GYRO) || (cmd_q == CMD_BOTH);
				flags.cal_mag = (cmd_q == CMD_MAG);
			end
			if (fc_q == FC_REQ) begin
				flags.readback = (cmd_q == CMD_READBACK);
				flags.version = (cmd_q == CMD_VERSION);
			end
			flags.save = gain_fc;
		end
	end

	assign q_push = accept && (rx_data.frame_end || in_store);

	always_comb begin
		q_wdata = '0;
		q_wdata.job = rx_data.frame_end;
		q_wdata.data = rx_data.rx_byte;
		q_wdata.addr = idx[PAY_IDX_W-1:0];
		if (rx_data.frame_end) begin
			q_wdata.status = status;
			q_wdata.flags = flags;
			q_wdata.fc = fc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			hdr_q <= 1'b1;
			fc_q <= '0;
			cmd_q <= '0;
		end else if (accept) begin
			if (rx_data.frame_end) begin
				pos_q <= '0;
				sum_q <= '0;
				hdr_q <= 1'b1;
				fc_q <= '0;
			end else begin
				if (pos_q == 8'd0 && rx_data.rx_byte != HDR0)
					hdr_q <= 1'b0;
				if (pos_q == 8'd1 && rx_data.rx_byte != HDR1)
					hdr_q <= 1'b0;
				if (pos_q == 8'd2)
					fc_q <= rx_data.rx_byte;
				// command byte kept here so flags are known at frame end
				if (pos_q == 8'd4)
					cmd_q <= rx_data.rx_byte;
				sum_q <= sum_q + rx_data.rx_byte;
				if (pos_q != 8'hFF)
					pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcfr_queue.sv =====
// tcfr_queue: short fifo of payload writes and frame jobs between front and back
// depends on tcfr_pkg
`default_nettype none
module tcfr_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  tcfr_pkg::q_entry_t    wdata,
	output logic                  full,
	input  wire                   pop,
	output logic                  empty,
	output tcfr_pkg::q_entry_t    head
);
	import tcfr_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	q_entry_t         slot_q [QDEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;

	assign full = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcfr_back.sv =====
// tcfr_back: drains the queue, holds the gain payload memory, sequences status,
// gain writes and acknowledge bytes into an output register; depends on tcfr_pkg
`default_nettype none
module tcfr_back #(
	parameter int GAINS_PER_GROUP = tcfr_pkg::GAINS_PER_GROUP_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_empty,
	input  tcfr_pkg::q_entry_t    q_head,
	output logic                  q_pop,
	output logic                  res_valid,
	input  wire                   res_stall,
	output tcfr_pkg::res_item_t   res_data
);
	import tcfr_pkg::*;

	localparam int AW = $clog2(GAINS_PER_GROUP);
	localparam int CW = $clog2(GAINS_PER_GROUP + 1);
	localparam int G13 = (GAINS_PER_GROUP < 3) ? GAINS_PER_GROUP : 3;

	back_state_t state_q, state_d;
	logic [7:0]  mem_hi [GAINS_PER_GROUP];
	logic [7:0]  mem_lo [GAINS_PER_GROUP];
	logic [7:0]  rd_hi_q, rd_lo_q;
	logic [7:0]  fc_q, sum_q;
	logic [5:0]  slot_q;
	logic [CW-1:0] gi_q, gains_q;
	logic [2:0]  k_q;
	logic        ack_q;
	logic        out_valid_q;
	res_item_t   out_q, res_d;
	logic        can_load, load, mem_we, head_more, last_gain;

	assign can_load = !out_valid_q || !res_stall;
	assign head_more = (q_head.status == ST_OK) &&
		(is_gain_fc(q_head.fc) || is_ack_fc(q_head.fc));
	assign last_gain = (gi_q == gains_q - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && q_head.job && can_load && head_more) begin
					if (q_head.status == ST_OK && is_gain_fc(q_head.fc))
						state_d = BK_GRD;
					else
						state_d = BK_ACK;
				end
			end
			BK_GRD: state_d = BK_GOUT;
			BK_GOUT: begin
				if (can_load) begin
					if (!last_gain)
						state_d = BK_GRD;
					else if (ack_q)
						state_d = BK_ACK;
					else
						state_d = BK_IDLE;
				end
			end
			BK_ACK: begin
				if (can_load && k_q == ACK_LAST)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop = 1'b0;
		mem_we = 1'b0;
		load = 1'b0;
		res_d = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (!q_head.job) begin
						q_pop = 1'b1;
						mem_we = 1'b1;
					end else if (can_load) begin
						q_pop = 1'b1;
						load = 1'b1;
						res_d.result_kind = KIND_STATUS;
						res_d.frame_status = q_head.status;
						res_d.calibrate_accel = q_head.flags.cal_accel;
						res_d.calibrate_gyro = q_head.flags.cal_gyro;
						res_d.calibrate_mag = q_head.flags.cal_mag;
						res_d.want_gain_readback = q_head.flags.readback;
						res_d.want_version = q_head.flags.version;
						res_d.save_params = q_head.flags.save;
						res_d.last_result = !head_more;
					end
				end
			end
			BK_GRD: ;
			BK_GOUT: begin
				load = can_load;
				res_d.result_kind = KIND_GAIN;
				res_d.gain_slot = slot_q;
				res_d.gain_value = {rd_hi_q, rd_lo_q};
				res_d.last_result = last_gain && !ack_q;
			end
			BK_ACK: begin
				load = can_load;
				res_d.result_kind = KIND_ACK;
				res_d.ack_byte = ack_byte_f(k_q, fc_q, sum_q);
				res_d.last_result = (k_q == ACK_LAST);
			end
			default: ;
		endcase
	end

	// payload memory, big-endian pairs split into high and low bytes
	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (q_head.addr[0])
				mem_lo[q_head.addr[AW:1]] <= q_head.data;
			else
				mem_hi[q_head.addr[AW:1]] <= q_head.data;
		end
		rd_hi_q <= mem_hi[gi_q[AW-1:0]];
		rd_lo_q <= mem_lo[gi_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.job) begin
			fc_q <= q_head.fc;
			sum_q <= q_head.data;
			ack_q <= is_ack_fc(q_head.fc);
			slot_q <= 6'(q_head.fc[1:0]) * 6'(GAINS_PER_GROUP);
			gi_q <= '0;
			gains_q <= (q_head.fc == FC_GAIN_SHORT) ? CW'(G13) : CW'(GAINS_PER_GROUP);
			k_q <= '0;
		end else if (load && state_q == BK_GOUT && !last_gain) begin
			gi_q <= gi_q + 1'b1;
			slot_q <= slot_q + 6'd1;
		end else if (load && state_q == BK_ACK) begin
			k_q <= k_q + 3'd1;
		end
		if (load)
			out_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data = out_q;

endmodule
`default_nettype wire

// ===== rtl/telemetry_command_frame_receiver_top.sv =====
// telemetry_command_frame_receiver_top: frame byte receiver with checksum and header check
// instantiates tcfr_front, tcfr_queue and tcfr_back; depends on tcfr_pkg
//
//   channel  direction  payload       handshake
//   rx       in         rx_item_t     rx_valid / rx_stall
//   res      out        res_item_t    res_valid / res_stall
//
// a byte is taken whenever rx_valid is high and the four-entry queue has room
// the back end stores payload bytes and emits status in idle, ack bytes in its ack state;
// a gain write takes a read state (registered payload memory read) and an output state
// a frame end at the queue head yields its registered status once the back end is idle
// reset clears the frame state, the queue and res_valid; payload memory is not reset
// either side may stall without losing data; rx_stall is high only while the queue is full
`default_nettype none
module telemetry_command_frame_receiver_top #(
	parameter int GAINS_PER_GROUP = tcfr_pkg::GAINS_PER_GROUP_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rx_valid,
	output logic                  rx_stall,
	input  tcfr_pkg::rx_item_t    rx_data,
	output logic                  res_valid,
	input  wire                   res_stall,
	output tcfr_pkg::res_item_t   res_data
);
	import tcfr_pkg::*;

	q_entry_t q_wdata, q_head;
	logic     q_push, q_pop, q_full, q_empty;

	tcfr_front #(.GAINS_PER_GROUP(GAINS_PER_GROUP)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_data  (rx_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	tcfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	tcfr_back #(.GAINS_PER_GROUP(GAINS_PER_GROUP)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
`default_nettype wire
